### hw/rtl/hfmd_pkg.sv
// ---------------------------------------------------------------------------
// hfmd_pkg
// Shared types and constants of the min-pooling height grid downsampler.
// ---------------------------------------------------------------------------
package hfmd_pkg;

    localparam int COORD_W    = 7;   // sample and vertex coordinates
    localparam int HEIGHT_W   = 32;  // height field on the stream ports
    localparam int LOD_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int N_RES      = 4;   // results one sample can release
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;
    localparam int M_PAD_W    = M_TDATA_W - 2 * COORD_W - HEIGHT_W;

    localparam logic [COORD_W-1:0] GRID_SIDE_RST = 7'd65;
    localparam logic [LOD_W-1:0]   LOD_RST       = 4'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_SIDE = 2'd0,
        CFG_LOD_LEVEL = 2'd1
    } t_cfg_idx;

    // Control of one sample that lands on a quad column boundary
    typedef struct packed {
        logic [COORD_W-1:0] qi;        // quad column
        logic [COORD_W-1:0] qj;        // quad row (valid on a row boundary)
        logic [COORD_W-1:0] lastc;     // last coarse index
        logic               y_zero;    // first grid row
        logic               y_bnd;     // row boundary: quad closes
        logic               y_lt_lim;  // not on the last coarse row
        logic               q_first;   // first quad column
        logic               row_top;   // first quad row
        logic               last_col;  // last quad column
        logic               last_row;  // last quad row
    } t_scan_ctl;

    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_vtx;

endpackage

### hw/rtl/hfmd_ram.sv
// ---------------------------------------------------------------------------
// hfmd_ram
// One-write, one-read synchronous memory, registered read, write-through on
// a same-address read and write in one cycle.
// ---------------------------------------------------------------------------
module hfmd_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wa,
    input  logic [W-1:0]  i_wd,
    input  logic          i_re,
    input  logic [AW-1:0] i_ra,
    output logic [W-1:0]  o_rd
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_wa == i_ra)) begin
                r_rd <= i_wd;
            end else begin
                r_rd <= r_mem[i_ra];
            end
        end
    end

    assign o_rd = r_rd;

endmodule

### hw/rtl/hfmd_scan.sv
// ---------------------------------------------------------------------------
// hfmd_scan
// Configuration registers, raster position and the running row-segment
// minimum; flags samples that land on a quad column boundary.
// ---------------------------------------------------------------------------
module hfmd_scan
    import hfmd_pkg::*;
#(
    parameter int SIDE_LIM    = 65,
    parameter int HEIGHT_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_accept,
    input  logic signed [HEIGHT_BITS-1:0] i_height,
    output logic                          o_op,
    output t_scan_ctl                     o_ctl,
    output logic signed [HEIGHT_BITS-1:0] o_seg
);

    localparam logic [COORD_W-1:0] SIDE_CAP = COORD_W'(SIDE_LIM);
    localparam logic signed [HEIGHT_BITS-1:0] HMAX = {1'b0, {(HEIGHT_BITS-1){1'b1}}};

    logic [COORD_W-1:0]            r_grid_side;
    logic [LOD_W-1:0]              r_lod;
    logic [COORD_W-1:0]            r_x, r_y;
    logic signed [HEIGHT_BITS-1:0] r_lqm;

    logic [COORD_W-1:0] n_x, n_y;
    logic [COORD_W-1:0] side, lastc, lim, step_mask, qi, qj;
    logic [COORD_W:0]   x_inc, y_inc;
    logic               active, in_rng, x_bnd;
    logic signed [HEIGHT_BITS-1:0] seg;

    always_comb begin
        side      = (r_grid_side > SIDE_CAP) ? SIDE_CAP : r_grid_side;
        lastc     = (side - COORD_W'(1)) >> r_lod;
        lim       = lastc << r_lod;
        // all ones once the step exceeds the coordinate range
        step_mask = (COORD_W'(1) << r_lod) - COORD_W'(1);
        active    = (side >= COORD_W'(2)) && (lastc != '0);
        in_rng    = (r_x <= lim) && (r_y <= lim);
        x_bnd     = (r_x != '0) && ((r_x & step_mask) == '0);
        seg       = (r_x == '0) ? i_height : ((r_lqm < i_height) ? r_lqm : i_height);
        qi        = (r_x >> r_lod) - COORD_W'(1);
        qj        = (r_y >> r_lod) - COORD_W'(1);

        x_inc = {1'b0, r_x} + (COORD_W+1)'(1);
        y_inc = {1'b0, r_y} + (COORD_W+1)'(1);
        n_x   = x_inc[COORD_W-1:0];
        n_y   = r_y;
        if (x_inc >= {1'b0, side}) begin
            n_x = '0;
            n_y = (y_inc >= {1'b0, side}) ? '0 : y_inc[COORD_W-1:0];
        end

        o_op           = active && in_rng && x_bnd;
        o_seg          = seg;
        o_ctl.qi       = qi;
        o_ctl.qj       = qj;
        o_ctl.lastc    = lastc;
        o_ctl.y_zero   = (r_y == '0);
        o_ctl.y_bnd    = (r_y != '0) && ((r_y & step_mask) == '0);
        o_ctl.y_lt_lim = (r_y < lim);
        o_ctl.q_first  = (qi == '0);
        o_ctl.row_top  = (qj == '0);
        o_ctl.last_col = (qi == lastc - COORD_W'(1));
        o_ctl.last_row = (qj == lastc - COORD_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_side <= GRID_SIDE_RST;
            r_lod       <= LOD_RST;
            r_x         <= '0;
            r_y         <= '0;
            r_lqm       <= HMAX;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GRID_SIDE: begin
                    r_grid_side <= i_cfg_data;
                    r_x         <= '0;
                    r_y         <= '0;
                end
                CFG_LOD_LEVEL: begin
                    r_lod <= i_cfg_data[LOD_W-1:0];
                    r_x   <= '0;
                    r_y   <= '0;
                end
                default: begin
                end
            endcase
        end else if (i_accept && active) begin
            r_x <= n_x;
            r_y <= n_y;
            if (in_rng) begin
                r_lqm <= x_bnd ? i_height : seg;
            end
        end
    end

endmodule

### hw/rtl/hfmd_merge.sv
// ---------------------------------------------------------------------------
// hfmd_merge
// Boundary stage: folds the segment minimum into the open quad, closes quads
// on row boundaries, writes both quad memories back and forms the vertices.
// ---------------------------------------------------------------------------
module hfmd_merge
    import hfmd_pkg::*;
#(
    parameter int HEIGHT_BITS = 32,
    parameter int AW          = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  t_scan_ctl                     i_ctl,
    input  logic signed [HEIGHT_BITS-1:0] i_seg,
    input  logic signed [HEIGHT_BITS-1:0] i_rd_open,
    input  logic signed [HEIGHT_BITS-1:0] i_rd_up,
    input  logic                          i_emit_free,
    output logic                          o_free,
    output logic                          o_open_we,
    output logic [AW-1:0]                 o_open_wa,
    output logic signed [HEIGHT_BITS-1:0] o_open_wd,
    output logic                          o_up_we,
    output logic [AW-1:0]                 o_up_wa,
    output logic signed [HEIGHT_BITS-1:0] o_up_wd,
    output logic                          o_emit_load,
    output logic [N_RES-1:0]              o_res_mask,
    output t_vtx                          o_res_vtx [N_RES],
    output logic signed [HEIGHT_BITS-1:0] o_res_h [N_RES]
);

    localparam logic signed [HEIGHT_BITS-1:0] HMAX = {1'b0, {(HEIGHT_BITS-1){1'b1}}};

    function automatic logic signed [HEIGHT_BITS-1:0] smin(
        input logic signed [HEIGHT_BITS-1:0] a,
        input logic signed [HEIGHT_BITS-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    logic                          r_valid;
    t_scan_ctl                     r_ctl;
    logic signed [HEIGHT_BITS-1:0] r_seg;
    logic signed [HEIGHT_BITS-1:0] r_lfm;   // final min of quad to the left
    logic signed [HEIGHT_BITS-1:0] r_upl;   // upper min of quad to the left

    logic adv;
    logic signed [HEIGHT_BITS-1:0] q, up, pair, upl, lq;

    always_comb begin
        adv  = r_valid && (!r_ctl.y_bnd || i_emit_free);
        q    = smin(i_rd_open, r_seg);
        up   = r_ctl.row_top ? HMAX : i_rd_up;
        pair = smin(up, q);
        upl  = r_ctl.row_top ? HMAX : r_upl;
        lq   = smin(upl, r_lfm);

        o_free      = !r_valid || adv;
        o_open_we   = adv && !(r_ctl.y_bnd && !r_ctl.y_lt_lim);
        o_open_wa   = r_ctl.qi[AW-1:0];
        o_open_wd   = (r_ctl.y_zero || r_ctl.y_bnd) ? r_seg : q;
        o_up_we     = adv && r_ctl.y_bnd;
        o_up_wa     = r_ctl.qi[AW-1:0];
        o_up_wd     = q;
        o_emit_load = adv && r_ctl.y_bnd;

        o_res_mask = {r_ctl.last_col && r_ctl.last_row, r_ctl.last_row,
                      r_ctl.last_col, 1'b1};
        o_res_vtx[0] = '{done: 1'b0, row: r_ctl.qj,    col: r_ctl.qi};
        o_res_vtx[1] = '{done: 1'b0, row: r_ctl.qj,    col: r_ctl.lastc};
        o_res_vtx[2] = '{done: 1'b0, row: r_ctl.lastc, col: r_ctl.qi};
        o_res_vtx[3] = '{done: 1'b1, row: r_ctl.lastc, col: r_ctl.lastc};
        o_res_h[0]   = r_ctl.q_first ? pair : smin(lq, pair);
        o_res_h[1]   = pair;
        o_res_h[2]   = r_ctl.q_first ? q : smin(r_lfm, q);
        o_res_h[3]   = q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ctl <= i_ctl;
            r_seg <= i_seg;
        end
        if (adv && r_ctl.y_bnd) begin
            r_lfm <= q;
            r_upl <= up;
        end
    end

endmodule

### hw/rtl/hfmd_emit.sv
// ---------------------------------------------------------------------------
// hfmd_emit
// Result register bank: holds the vertices released by one sample and
// presents them in order on the output stream, one per cycle while it is ready.
// ---------------------------------------------------------------------------
module hfmd_emit
    import hfmd_pkg::*;
#(
    parameter int HEIGHT_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [N_RES-1:0]              i_mask,
    input  t_vtx                          i_vtx [N_RES],
    input  logic signed [HEIGHT_BITS-1:0] i_h [N_RES],
    input  logic                          i_ready,
    output logic                          o_free,
    output logic                          o_valid,
    output logic                          o_last,
    output t_vtx                          o_vtx,
    output logic signed [HEIGHT_BITS-1:0] o_h
);

    localparam int SW = $clog2(N_RES);

    logic [N_RES-1:0]              r_mask;
    t_vtx                          r_vtx [N_RES];
    logic signed [HEIGHT_BITS-1:0] r_h [N_RES];

    logic [SW-1:0]    sel;
    logic [N_RES-1:0] cur_bit;

    always_comb begin
        sel = '0;
        for (int k = N_RES - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                sel = SW'(k);
            end
        end
        cur_bit = N_RES'(1) << sel;
        o_valid = (r_mask != '0);
        o_last  = o_valid && (r_mask == cur_bit);
        o_free  = !o_valid || (o_last && i_ready);
        o_vtx   = r_vtx[sel];
        o_h     = r_h[sel];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_load) begin
            r_mask <= i_mask;
        end else if (o_valid && i_ready) begin
            r_mask <= r_mask & ~cur_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < N_RES; k++) begin
                r_vtx[k] <= i_vtx[k];
                r_h[k]   <= i_h[k];
            end
        end
    end

endmodule

### hw/rtl/heightfield_min_downsample.sv
// ---------------------------------------------------------------------------
// heightfield_min_downsample
// Min-pooling downsampler for a square height grid streamed in raster order.
// ---------------------------------------------------------------------------
// Takes one height sample per transfer and emits, for each coarse vertex, the
// minimum over its adjacent quads as soon as they are complete. A sample is
// normally taken every cycle. A sample that closes a quad releases one to four
// vertices into a result bank that sends them one per cycle while the output
// is ready, the first one offered once that sample has left the boundary stage
// register for the bank. The next closing sample waits in the boundary stage
// until the bank's last vertex is taken, and no sample is taken while it waits.
// Per quad column, two synchronous memories hold the open quad minimum and the
// finished upper quad minimum; each is read at sample entry and written from
// the boundary stage, with write-through covering back-to-back access.
// Grid side and LOD level writes restart the raster position at the grid origin.
module heightfield_min_downsample
    import hfmd_pkg::*;
#(
    parameter int MAX_SIDE    = 65,
    parameter int HEIGHT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,   // [31:0] height
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,   // [6:0] vertex_col, [13:7] vertex_row,
                                                    // [45:14] min_height, [47:46] zero
    output logic                  o_m_axis_tuser,   // [0] grid_done
    output logic                  o_m_axis_tlast,   // run_last
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SIDE_LIM = (MAX_SIDE < (1 << COORD_W)) ? MAX_SIDE : (1 << COORD_W) - 1;
    localparam int DEPTH    = SIDE_LIM - 1;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                          accept, op, s1_free, emit_free, emit_load;
    t_scan_ctl                     ctl;
    logic signed [HEIGHT_BITS-1:0] s_h, seg, rd_open, rd_up;
    logic                          open_we, up_we;
    logic [AW-1:0]                 open_wa, up_wa;
    logic signed [HEIGHT_BITS-1:0] open_wd, up_wd;
    logic [N_RES-1:0]              res_mask;
    t_vtx                          res_vtx [N_RES];
    logic signed [HEIGHT_BITS-1:0] res_h [N_RES];
    t_vtx                          out_vtx;
    logic signed [HEIGHT_BITS-1:0] out_h;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = s1_free;
    assign accept          = i_s_axis_tvalid && s1_free;
    assign s_h             = HEIGHT_BITS'(i_s_axis_tdata[HEIGHT_W-1:0]);

    hfmd_scan #(
        .SIDE_LIM    (SIDE_LIM),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_height    (s_h),
        .o_op        (op),
        .o_ctl       (ctl),
        .o_seg       (seg)
    );

    hfmd_ram #(
        .W     (HEIGHT_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_open_ram (
        .i_clk (i_clk),
        .i_we  (open_we),
        .i_wa  (open_wa),
        .i_wd  (open_wd),
        .i_re  (accept && op),
        .i_ra  (ctl.qi[AW-1:0]),
        .o_rd  (rd_open)
    );

    hfmd_ram #(
        .W     (HEIGHT_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_up_ram (
        .i_clk (i_clk),
        .i_we  (up_we),
        .i_wa  (up_wa),
        .i_wd  (up_wd),
        .i_re  (accept && op),
        .i_ra  (ctl.qi[AW-1:0]),
        .o_rd  (rd_up)
    );

    hfmd_merge #(
        .HEIGHT_BITS (HEIGHT_BITS),
        .AW          (AW)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept && op),
        .i_ctl       (ctl),
        .i_seg       (seg),
        .i_rd_open   (rd_open),
        .i_rd_up     (rd_up),
        .i_emit_free (emit_free),
        .o_free      (s1_free),
        .o_open_we   (open_we),
        .o_open_wa   (open_wa),
        .o_open_wd   (open_wd),
        .o_up_we     (up_we),
        .o_up_wa     (up_wa),
        .o_up_wd     (up_wd),
        .o_emit_load (emit_load),
        .o_res_mask  (res_mask),
        .o_res_vtx   (res_vtx),
        .o_res_h     (res_h)
    );

    hfmd_emit #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit_load),
        .i_mask  (res_mask),
        .i_vtx   (res_vtx),
        .i_h     (res_h),
        .i_ready (i_m_axis_tready),
        .o_free  (emit_free),
        .o_valid (o_m_axis_tvalid),
        .o_last  (o_m_axis_tlast),
        .o_vtx   (out_vtx),
        .o_h     (out_h)
    );

    assign o_m_axis_tdata = {M_PAD_W'(0), HEIGHT_W'(out_h), out_vtx.row, out_vtx.col};
    assign o_m_axis_tuser = out_vtx.done;

endmodule

### hw/rtl/hfmd_checker.sv
// ---------------------------------------------------------------------------
// hfmd_checker
// Port-level checks on the result stream of the downsampler.
// ---------------------------------------------------------------------------
module hfmd_checker
    import hfmd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    input logic                  o_m_axis_tuser,
    input logic                  o_m_axis_tlast
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result withdrawn while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // the closing corner vertex ends its run and sits on the diagonal
    a_done_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            o_m_axis_tlast &&
            (o_m_axis_tdata[COORD_W-1:0] == o_m_axis_tdata[2*COORD_W-1:COORD_W]))
        else $error("grid end flagged on a non-final corner");

    // a run of results from one sample goes out without gaps
    a_run_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=> o_m_axis_tvalid)
        else $error("gap inside a result run");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered after reset");

endmodule

bind heightfield_min_downsample hfmd_checker u_hfmd_checker (.*);
